>>> design/mono_mixdown_linear_resampler_macros.svh
// Assertion helpers shared by the resampler modules.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef MONO_MIXDOWN_LINEAR_RESAMPLER_MACROS_SVH
`define MONO_MIXDOWN_LINEAR_RESAMPLER_MACROS_SVH

// same-cycle implication
`define MMLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MMLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mmlr_pkg.sv
package mmlr_pkg;

    localparam int CNT_W     = 4;
    localparam int OUT_SHIFT = 4;
    localparam int MAX_OUT   = 16;
    localparam int OUT_CNT_W = 5;

    typedef enum logic {
        REG_CHANNEL_COUNT = 1'b0,
        REG_STEP_RATIO    = 1'b1
    } cfg_reg_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_CHECK  = 6'b000100,
        S_MUL    = 6'b001000,
        S_EMIT   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic emit;
        logic cap;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic bypass;
        logic primed;
        logic phase_lt_one;
        logic run_end;
        logic out_free;
    } sts_t;

endpackage

>>> design/mmlr_ctrl.sv
`include "mono_mixdown_linear_resampler_macros.svh"

module mmlr_ctrl
    import mmlr_pkg::*;
#(
    parameter int DIV_STEPS = 19
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int DCNT_W = $clog2(DIV_STEPS);

    state_t                 state_reg, state_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic [OUT_CNT_W-1:0]   ocnt_reg, ocnt_next;
    logic                   cap;
    logic                   run_done;

    assign cap      = (ocnt_reg == OUT_CNT_W'(MAX_OUT - 1));
    assign run_done = sts.bypass || sts.run_end || cap;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        ocnt_next  = ocnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.bypass)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.primed && sts.phase_lt_one)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.cap    = cap;
                    ocnt_next  = ocnt_reg + 1'b1;
                    state_next = run_done ? S_FINISH : S_MUL;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                ocnt_next  = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dcnt_reg  <= '0;
            ocnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    `MMLR_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "emit while output register busy")
    `MMLR_ASSERT_NOW(a_cnt_bound, 1'b1, ocnt_reg <= OUT_CNT_W'(MAX_OUT), "too many results")
    `MMLR_ASSERT_NOW(a_idle_clear, state_reg == S_IDLE, ocnt_reg == '0, "result count not cleared")

endmodule

>>> design/mmlr_dp.sv
`include "mono_mixdown_linear_resampler_macros.svh"

module mmlr_dp
    import mmlr_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_index,
    input  logic [FRAC_BITS+3:0]                 cfg_data,
    input  logic [MAX_CHANNELS*SAMPLE_WIDTH-1:0] in_samples,
    input  logic                                 in_eos,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [SAMPLE_WIDTH-1:0]              out_sample,
    output logic                                 out_last,
    input  cmd_t                                 cmd,
    output sts_t                                 sts
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int SUM_W  = SAMPLE_WIDTH + 3;
    localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int STEP_W = FRAC_BITS + 4;
    localparam int PH_W   = FRAC_BITS + 5;
    localparam int PR_W   = FRAC_BITS + SAMPLE_WIDTH + 2;

    localparam logic [PH_W-1:0]   PH_ONE   = PH_W'(1) << FRAC_BITS;
    localparam logic [PH_W-1:0]   PH_BOUND = PH_W'(17) << FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(1) << (FRAC_BITS - OUT_SHIFT);
    localparam logic [PR_W-1:0]   RND_HALF = PR_W'(1) << (FRAC_BITS - 1);

    // configuration
    logic [CNT_W-1:0]  channel_count_reg;
    logic [STEP_W-1:0] step_ratio_reg;

    // resampler state
    logic [SW-1:0]     prev_reg;
    logic              primed_reg;
    logic [PH_W-1:0]   phase_reg, phase_next;

    // per-item working registers
    logic [SUM_W-1:0]  quo_reg;
    logic [NCH_W-1:0]  rem_reg;
    logic [NCH_W-1:0]  div_reg;
    logic              neg_reg;
    logic              eos_reg;
    logic signed [PR_W-1:0] prod_reg;

    logic              out_valid_reg;
    logic [SW-1:0]     out_data_reg;
    logic              out_last_reg;

    logic [NCH_W-1:0]  nch_eff;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]  sum_mag;
    logic [NCH_W:0]    rem_shift;
    logic              quo_bit;
    logic [SUM_W-1:0]  quo_signed;
    logic [SW-1:0]     cur;
    logic signed [SW:0]     diff;
    logic signed [FRAC_BITS:0] phase_frac;
    logic signed [PR_W-1:0] prod_rnd;
    logic [SW-1:0]     interp;
    logic [STEP_W-1:0] step_eff;
    logic              bypass;
    logic              emit_last;

    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            nch_eff = NCH_W'(1);
        end
        else if (channel_count_reg > CNT_W'(MAX_CHANNELS))
        begin
            nch_eff = NCH_W'(MAX_CHANNELS);
        end
        else
        begin
            nch_eff = channel_count_reg[NCH_W-1:0];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int ch = 0; ch < MAX_CHANNELS; ch++)
        begin
            if (NCH_W'(ch) < nch_eff)
            begin
                sum = sum + SUM_W'(signed'(in_samples[ch*SW +: SW]));
            end
        end
    end

    assign sum_mag    = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
    assign rem_shift  = {rem_reg, quo_reg[SUM_W-1]};
    assign quo_bit    = (rem_shift >= {1'b0, div_reg});
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign cur        = quo_signed[SW-1:0];

    assign diff       = {cur[SW-1], cur} - {prev_reg[SW-1], prev_reg};
    assign phase_frac = {1'b0, phase_reg[FRAC_BITS-1:0]};
    assign prod_rnd   = prod_reg + RND_HALF;
    assign interp     = prev_reg + prod_rnd[FRAC_BITS +: SW];

    assign step_eff   = (step_ratio_reg < MIN_STEP) ? MIN_STEP : step_ratio_reg;
    assign bypass     = (step_ratio_reg == STEP_ONE);
    assign phase_next = phase_reg + PH_W'(step_eff);
    assign emit_last  = bypass || (phase_next >= PH_ONE) || cmd.cap;

    assign sts.bypass       = bypass;
    assign sts.primed       = primed_reg;
    assign sts.phase_lt_one = (phase_reg < PH_ONE);
    assign sts.run_end      = (phase_next >= PH_ONE);
    assign sts.out_free     = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_data_reg;
    assign out_last   = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CNT_W'(1);
            step_ratio_reg    <= STEP_ONE;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_CHANNEL_COUNT)
            begin
                channel_count_reg <= cfg_data[CNT_W-1:0];
            end
            else
            begin
                step_ratio_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            primed_reg    <= 1'b0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (!bypass)
                begin
                    phase_reg <= phase_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.finish)
            begin
                if (eos_reg)
                begin
                    prev_reg   <= '0;
                    primed_reg <= 1'b0;
                    phase_reg  <= '0;
                end
                else
                begin
                    prev_reg   <= cur;
                    primed_reg <= 1'b1;
                    if (!bypass && primed_reg && (phase_reg >= PH_ONE))
                    begin
                        phase_reg <= phase_reg - PH_ONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg <= sum_mag;
            rem_reg <= '0;
            div_reg <= nch_eff;
            neg_reg <= sum[SUM_W-1];
            eos_reg <= in_eos;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], quo_bit};
            rem_reg <= quo_bit ? NCH_W'(rem_shift - {1'b0, div_reg}) : rem_shift[NCH_W-1:0];
        end

        if (cmd.mul)
        begin
            prod_reg <= PR_W'(phase_frac) * PR_W'(diff);
        end

        if (cmd.emit)
        begin
            out_data_reg <= bypass ? cur : interp;
            out_last_reg <= emit_last;
        end
    end

    `MMLR_ASSERT_NEXT(a_eos_clear, cmd.finish && eos_reg, !primed_reg && (phase_reg == '0), "stream end did not clear state")
    `MMLR_ASSERT_NOW(a_phase_bound, 1'b1, phase_reg < PH_BOUND, "phase out of range")
    `MMLR_ASSERT_NEXT(a_cap_last, cmd.emit && cmd.cap, out_last_reg, "run limit without last mark")

endmodule

>>> design/mono_mixdown_linear_resampler.sv
// Mono mixdown and linear-interpolation sample rate converter.
// s_axis: one multichannel frame per transfer; tdata holds chan0..chan7, tlast marks
//   the end of the stream (phase and history clear after that frame).
// m_axis: interpolated mono samples; tlast marks the last sample caused by a frame.
// cfg: register writes (index 0 channel_count, index 1 step_ratio), always ready;
//   write only while the block is idle.
// Per frame: accept, the bit-serial averaging divider, a decision step, then per emitted
//   sample a multiply and an output load, and a closing step; N results (0..16) per frame.
//   Unity ratio gives one result straight from the average, with no multiply.
// Frames are taken one at a time; s_axis_tready is high only between frames.
// The output register holds a result until taken; when m_axis_tready is low the
//   block stops at the next result and waits, nothing is dropped.
// Reset clears phase, history and output valid and restores channel_count = 1,
//   step_ratio = 1.0; the block is ready in the first cycle after reset.
module mono_mixdown_linear_resampler
    import mmlr_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic                                          cfg_index,
    input  logic [FRAC_BITS+3:0]                          cfg_data,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // chan0_sample .. chan7_sample, zero padded to bytes
    input  logic [((MAX_CHANNELS*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                          s_axis_tlast,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // out_sample, zero padded to bytes
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]              m_axis_tdata,
    output logic                                          m_axis_tlast
);

    localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    cmd_t                    cmd;
    sts_t                    sts;
    logic [SAMPLE_WIDTH-1:0] out_sample;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = OUT_W'(out_sample);

    mmlr_ctrl #(
        .DIV_STEPS (SAMPLE_WIDTH + 3)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mmlr_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_samples (s_axis_tdata[MAX_CHANNELS*SAMPLE_WIDTH-1:0]),
        .in_eos     (s_axis_tlast),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_sample (out_sample),
        .out_last   (m_axis_tlast),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule
